@@ hdl/dkwm_pkg.sv @@
package dkwm_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 32;
  localparam int LEN_W      = 6;
  localparam int CODE_W     = 4;
  localparam int SYM_CNT    = 32;
  localparam int SYM_IDX_W  = 5;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int PATTERN_MAX_DEFAULT = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH   = 2'd2;

  // pattern symbol codes, anything at or above CODE_ANY is a wildcard
  localparam logic [CODE_W-1:0] CODE_A   = 4'd0;
  localparam logic [CODE_W-1:0] CODE_C   = 4'd1;
  localparam logic [CODE_W-1:0] CODE_G   = 4'd2;
  localparam logic [CODE_W-1:0] CODE_T   = 4'd3;
  localparam logic [CODE_W-1:0] CODE_ANY = 4'd4;

  localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_G = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;

  typedef logic [BYTE_W-1:0] base_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [SYM_CNT-1:0][CODE_W-1:0] pattern_t;

  typedef struct packed {
    logic [POS_W-1:0] start_position;
    logic             strand;
  } hit_t;

  function automatic base_t code_letter(input logic [CODE_W-1:0] code);
    base_t letter;
    case (code)
      CODE_A:  letter = CHAR_A;
      CODE_C:  letter = CHAR_C;
      CODE_G:  letter = CHAR_G;
      default: letter = CHAR_T;
    endcase
    return letter;
  endfunction

  // complement flips A<->T and C<->G, which is 3 - code on the two low bits
  function automatic logic sym_match(input logic [CODE_W-1:0] code, input base_t base,
                                     input logic complement);
    logic [CODE_W-1:0] eff;
    if (code >= CODE_ANY) begin
      return 1'b1;
    end
    eff = complement ? (CODE_T - code) : code;
    return base == code_letter(eff);
  endfunction

endpackage

@@ hdl/dkwm_cell.sv @@
module dkwm_cell import dkwm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     shift_en,
  input  logic     clear,
  input  base_t    base_in,
  input  pattern_t pattern,
  input  len_t     len_eff,
  output base_t    base_out,
  output logic     fwd_ok,
  output logic     rev_ok
);

  base_t base_r;
  len_t  fwd_pos;
  logic  active;

  // window slot IDX counts from the newest base; forward reads symbols from the oldest
  assign fwd_pos = len_eff - LEN_W'(IDX) - LEN_W'(1);
  assign active  = LEN_W'(IDX) < len_eff;

  assign fwd_ok = !active ||
                  sym_match(pattern[fwd_pos[SYM_IDX_W-1:0]], base_in, 1'b0);
  assign rev_ok = !active ||
                  sym_match(pattern[SYM_IDX_W'(IDX)], base_in, 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (shift_en) begin
      base_r <= clear ? '0 : base_in;
    end
  end

  assign base_out = base_r;

endmodule

@@ hdl/dkwm_outq.sv @@
module dkwm_outq import dkwm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  hit_t push_item,
  input  logic pop,
  output logic head_valid,
  output hit_t head_item,
  output logic [$clog2(OUTQ_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH+1);

  hit_t             entry_r [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = count_r != '0;
  assign head_item  = entry_r[rd_ptr_r];
  assign count      = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == CNT_W'(OUTQ_DEPTH)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("result queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(OUTQ_DEPTH))
    else $error("result queue count out of range");

endmodule

@@ hdl/dna_kmer_wildcard_match_unit.sv @@
// streaming k-mer search over both strands of a DNA byte stream
//
// input channel: in_sequence_byte / in_end_of_record, one request per
//   cycle taken when in_valid is high and in_stall is low. whitespace
//   (0x09..0x0d, 0x20) is dropped, lower case folded to upper case.
//   in_end_of_record clears the base window and position after the byte.
// result channel: out_start_position (1-based) / out_strand (0 forward,
//   1 reverse complement), taken when out_valid is high and out_stall low.
//   forward wins when both strands hit.
// config channel: cfg_index / cfg_data, cfg_ready is always high; write
//   only while no request is in flight.
// path: a hit is registered in the reduce stage, then written into the
//   result queue, from which it shows on out_valid.
// throughput: one request per cycle unless stalled, set by the row of window
//   cells that each compare one base per cycle plus one and-reduce stage.
// stall: up to three results wait in the four-entry output queue; in_stall
//   comes from registered queue occupancy and the reduce stage valid, so it
//   rises before the queue overflows.
// reset: pattern length 1, all pattern symbols A, window and position
//   cleared, result queue empty.
module dna_kmer_wildcard_match_unit import dkwm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_sequence_byte,
  input  logic                 in_end_of_record,
  // result requests
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_W-1:0]     out_start_position,
  output logic                 out_strand,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  // configuration registers
  len_t             pat_len_r;
  logic [CFG_W-1:0] pat_low_r;
  logic [CFG_W-1:0] pat_high_r;

  pattern_t pattern;
  len_t     len_eff;

  // input side
  logic             in_acc;
  logic             is_space;
  base_t            base_up;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic             candidate;

  // cell row
  base_t                  cell_in  [PATTERN_MAX];
  base_t                  cell_out [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] fwd_ok;
  logic [PATTERN_MAX-1:0] rev_ok;

  // reduce stage
  logic                   s1_valid_r;
  logic [PATTERN_MAX-1:0] s1_fwd_r;
  logic [PATTERN_MAX-1:0] s1_rev_r;
  logic [POS_W-1:0]       s1_pos_r;
  len_t                   s1_len_r;
  logic                   fwd_hit;
  logic                   rev_hit;
  logic                   push;
  hit_t                   push_item;

  // output queue
  logic             q_valid;
  hit_t             q_item;
  logic [CNT_W-1:0] q_count;
  logic             out_acc;

  // ---------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= LEN_W'(1);
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pat_len_r  <= cfg_data[LEN_W-1:0];
        REG_SYMBOLS_LOW:    pat_low_r  <= cfg_data;
        REG_SYMBOLS_HIGH:   pat_high_r <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // symbol 0 sits in the low nibble of the low word
  assign pattern = {pat_high_r, pat_low_r};
  // lengths beyond the window depth act as a full window
  assign len_eff = (pat_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_r;

  // ---------------------------------------------------------------
  // input request: fold, count, decide whether a window closes
  // ---------------------------------------------------------------
  // hold input when the queue plus the request in the reduce stage could fill it
  assign in_stall = (q_count + CNT_W'(s1_valid_r)) >= CNT_W'(OUTQ_DEPTH - 1);
  assign in_acc   = in_valid && !in_stall;

  assign is_space = (in_sequence_byte == 8'h20) ||
                    (in_sequence_byte >= 8'h09 && in_sequence_byte <= 8'h0d);
  assign base_up  = (in_sequence_byte >= 8'h61 && in_sequence_byte <= 8'h7a) ?
                    in_sequence_byte - 8'h20 : in_sequence_byte;

  // position saturates at all ones
  assign pos_inc = (pos_r == '1) ? pos_r : pos_r + POS_W'(1);

  assign candidate = in_acc && !is_space && (len_eff != '0) &&
                     (pos_inc >= {{(POS_W-LEN_W){1'b0}}, len_eff});

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      if (in_end_of_record) begin
        pos_nxt = '0;
      end else if (!is_space) begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // ---------------------------------------------------------------
  // window cells: cell k holds the k-th newest base and compares the
  // base that shifts into it this cycle
  // ---------------------------------------------------------------
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = base_up;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end

    dkwm_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc && (!is_space || in_end_of_record)),
      .clear    (in_end_of_record),
      .base_in  (cell_in[k]),
      .pattern  (pattern),
      .len_eff  (len_eff),
      .base_out (cell_out[k]),
      .fwd_ok   (fwd_ok[k]),
      .rev_ok   (rev_ok[k])
    );
  end

  // ---------------------------------------------------------------
  // reduce stage: and across the row, form the start position
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= candidate;
    end
  end

  always_ff @(posedge clk) begin
    s1_fwd_r <= fwd_ok;
    s1_rev_r <= rev_ok;
    s1_pos_r <= pos_inc;
    s1_len_r <= len_eff;
  end

  assign fwd_hit = &s1_fwd_r;
  assign rev_hit = &s1_rev_r;
  assign push    = s1_valid_r && (fwd_hit || rev_hit);

  assign push_item.start_position = s1_pos_r - {{(POS_W-LEN_W){1'b0}}, s1_len_r} + POS_W'(1);
  assign push_item.strand         = !fwd_hit;

  // ---------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------
  assign out_acc = out_valid && !out_stall;

  dkwm_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (out_acc),
    .head_valid (q_valid),
    .head_item  (q_item),
    .count      (q_count)
  );

  assign out_valid          = q_valid;
  assign out_start_position = q_item.start_position;
  assign out_strand         = q_item.strand;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count + CNT_W'(s1_valid_r)) <= CNT_W'(OUTQ_DEPTH))
    else $error("results in flight exceed queue room");

  a_hit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("hit did not reach the result port");

  a_eor_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_record) |=> (pos_r == '0))
    else $error("end of record left a position");

  a_space_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_space) |=> !s1_valid_r)
    else $error("whitespace byte opened a window check");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_space && !in_end_of_record && pos_r != '1) |=>
      (pos_r == $past(pos_r) + POS_W'(1)))
    else $error("position did not advance on a base");

endmodule

@@ dv/dna_kmer_wildcard_match_checker.sv @@
`timescale 1ns / 100ps
module dna_kmer_wildcard_match_checker import dkwm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_sequence_byte,
  input  logic                 in_end_of_record,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [POS_W-1:0]     out_start_position,
  input  logic                 out_strand,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 wrap_up,
  output int                   mismatch_count,
  output int                   hits_pending,
  output int                   hits_seen
);

  localparam int    WIN_DEPTH = PATTERN_MAX_DEFAULT;
  localparam base_t SPACE     = 8'h20;
  localparam base_t WS_LO     = 8'h09;
  localparam base_t WS_HI     = 8'h0d;
  localparam base_t LOWER_A   = 8'h61;
  localparam base_t LOWER_Z   = 8'h7a;
  localparam base_t CASE_BIT  = 8'h20;

  base_t              window [WIN_DEPTH];  // newest base at 0
  logic [POS_W-1:0]   bases_seen;
  len_t               pat_len;
  logic [2*CFG_W-1:0] pat_codes;           // symbol j at bits 4j+3..4j
  hit_t               hits_due [$];
  logic               wrapped;

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic base_t base_letter(input logic [1:0] pick);
    case (pick)
      2'd0:    return CHAR_A;
      2'd1:    return CHAR_C;
      2'd2:    return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  // complement of a two-bit code is its bitwise inverse
  function automatic logic symbol_fits(input logic [CODE_W-1:0] code, input base_t b,
                                       input logic complement);
    logic [1:0] pick;
    if (code >= CODE_ANY) return 1'b1;
    pick = complement ? ~code[1:0] : code[1:0];
    return b == base_letter(pick);
  endfunction

  task automatic clear_window();
    foreach (window[k]) window[k] = '0;
    bases_seen = '0;
  endtask

  task automatic take_base(input base_t raw, input logic eor);
    base_t ch;
    int    span;
    logic  fwd;
    logic  rev;
    hit_t  hit;
    ch = raw;
    if (!(ch == SPACE || (ch >= WS_LO && ch <= WS_HI))) begin
      if (ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_BIT;
      for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = ch;
      if (bases_seen != '1) bases_seen = bases_seen + 1'b1;
      span = (pat_len > WIN_DEPTH) ? WIN_DEPTH : int'(pat_len);
      if (span != 0 && bases_seen >= POS_W'(span)) begin
        fwd = 1'b1;
        rev = 1'b1;
        for (int j = 0; j < span; j++) begin
          if (!symbol_fits(pat_codes[CODE_W*j +: CODE_W], window[span-1-j], 1'b0)) fwd = 1'b0;
          if (!symbol_fits(pat_codes[CODE_W*j +: CODE_W], window[j], 1'b1)) rev = 1'b0;
        end
        if (fwd || rev) begin
          hit.start_position = bases_seen - POS_W'(span) + 1'b1;
          hit.strand         = !fwd;
          hits_due.push_back(hit);
        end
      end
    end
    if (eor) clear_window();
  endtask

  always @(posedge clk) begin : watch
    hit_t want;
    if (!rst_n) begin
      clear_window();
      pat_len   = len_t'(1);
      pat_codes = '0;
      hits_due.delete();
      wrapped   = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        hits_seen++;
        if (hits_due.size() == 0) begin
          report($sformatf("hit at %0d strand %0d with none expected",
                           out_start_position, out_strand));
        end else begin
          want = hits_due.pop_front();
          if (out_start_position !== want.start_position)
            report($sformatf("start position %0d, expected %0d",
                             out_start_position, want.start_position));
          if (out_strand !== want.strand)
            report($sformatf("strand %0d at start %0d, expected %0d",
                             out_strand, want.start_position, want.strand));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          REG_SYMBOLS_LOW:    pat_codes[CFG_W-1:0] = cfg_data;
          REG_SYMBOLS_HIGH:   pat_codes[2*CFG_W-1:CFG_W] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_base(in_sequence_byte, in_end_of_record);
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        foreach (hits_due[k])
          report($sformatf("hit at %0d strand %0d never arrived",
                           hits_due[k].start_position, hits_due[k].strand));
        hits_due.delete();
      end
    end
    hits_pending = hits_due.size();
  end

endmodule

@@ dv/dna_kmer_wildcard_match_unit_tb.sv @@
`timescale 1ns / 100ps
module dna_kmer_wildcard_match_unit_tb;
  import dkwm_pkg::*;

  localparam int    RANDOM_BASES  = 1600;
  localparam int    BLOCK_BASES   = 100;
  localparam int    SETTLE_CYCLES = 4;      // a hit passes the reduce stage and the result queue before it shows
  localparam int    DRAIN_LIMIT   = 20000;
  localparam base_t CH_SPACE      = 8'h20;
  localparam base_t CH_TAB        = 8'h09;
  localparam base_t CH_LF         = 8'h0a;
  localparam base_t CH_CR         = 8'h0d;
  localparam base_t CH_N          = 8'h4e;
  localparam base_t CH_ZERO       = 8'h00;
  localparam base_t CH_ONES       = 8'hff;
  localparam base_t CASE_BIT      = 8'h20;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n              = 1'b0;
  logic                 in_valid           = 1'b0;
  logic                 in_stall;
  base_t                in_sequence_byte   = '0;
  logic                 in_end_of_record   = 1'b0;
  logic                 out_valid;
  logic                 out_stall          = 1'b0;
  logic [POS_W-1:0]     out_start_position;
  logic                 out_strand;
  logic                 cfg_valid          = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index          = '0;
  logic [CFG_W-1:0]     cfg_data           = '0;
  logic                 wrap_up            = 1'b0;
  int                   mismatch_count;
  int                   hits_pending;
  int                   hits_seen;

  // stimulus-side copy of the pattern, only used to build matching text
  len_t                 gen_len            = len_t'(1);
  logic [2*CFG_W-1:0]   gen_codes          = '0;
  int                   bases_sent         = 0;
  int                   gap_pct            = 0;
  int                   stall_pct          = 0;
  logic                 stuck              = 1'b0;

  dna_kmer_wildcard_match_unit u_top (.*);

  dna_kmer_wildcard_match_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("dna_kmer_wildcard_match_unit verification failed");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // register write, cfg_ready sampled mid-cycle so the edge decides nothing
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LENGTH: gen_len = data[LEN_W-1:0];
      REG_SYMBOLS_LOW:    gen_codes[CFG_W-1:0] = data;
      REG_SYMBOLS_HIGH:   gen_codes[2*CFG_W-1:CFG_W] = data;
      default: ;
    endcase
  endtask

  // one request: random idle gap first, then hold until taken
  task automatic push_byte(input base_t b, input logic eor);
    logic took;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sequence_byte <= b;
    in_end_of_record <= eor;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) bases_sent++;
  endtask

  task automatic push_word(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // sender holds off until every predicted hit has been taken
  task automatic quiesce();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (hits_pending != 0 && waited < DRAIN_LIMIT);
    if (hits_pending != 0) stuck = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic base_t char_for(input logic [1:0] pick);
    case (pick)
      2'd0:    return CHAR_A;
      2'd1:    return CHAR_C;
      2'd2:    return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  function automatic base_t blank_char();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + base_t'(r);
  endfunction

  // mostly ACGT, some N, a few arbitrary bytes; letters folded at random
  function automatic base_t filler();
    int    r;
    base_t b;
    r = $urandom_range(99);
    if (r >= 95) return base_t'($urandom_range(255));
    b = (r < 85) ? char_for(2'($urandom_range(3))) : CH_N;
    if ($urandom_range(99) < 30) b = b | CASE_BIT;
    return b;
  endfunction

  // the first count bases of one pattern occurrence, forward or reverse complement
  task automatic push_instance(input logic rev, input int span, input int count,
                               input logic eor_last);
    int               idx;
    logic [CODE_W-1:0] code;
    base_t            b;
    for (int i = 0; i < count; i++) begin
      idx  = rev ? span - 1 - i : i;
      code = gen_codes[CODE_W*idx +: CODE_W];
      if (code >= CODE_ANY) begin
        b = filler();
      end else begin
        b = char_for(rev ? ~code[1:0] : code[1:0]);
        if ($urandom_range(99) < 30) b = b | CASE_BIT;
      end
      if ($urandom_range(99) < 8) push_byte(blank_char(), 1'b0);
      push_byte(b, eor_last && i == count - 1);
    end
  endtask

  // well-formed record: background runs and pattern occurrences, closed by end of record
  task automatic send_record();
    int span;
    int segs;
    int r;
    span = (gen_len > PATTERN_MAX_DEFAULT) ? PATTERN_MAX_DEFAULT : int'(gen_len);
    segs = $urandom_range(1, 5);
    for (int s = 0; s < segs; s++) begin
      r = $urandom_range(99);
      if (span != 0 && r < 60) begin
        push_instance(r < 30, span, span, 1'b0);
      end else if (span > 1 && r < 68) begin
        // broken occurrence, the record ends before it completes
        push_instance(1'($urandom_range(1)), span, $urandom_range(1, span - 1), 1'b1);
        return;
      end else begin
        repeat ($urandom_range(0, 6)) begin
          push_byte(($urandom_range(99) < 10) ? blank_char() : filler(), 1'b0);
        end
      end
    end
    push_byte(($urandom_range(3) == 0) ? blank_char() : filler(), 1'b1);
  endtask

  // pure noise over the whole byte range, end of record anywhere
  task automatic send_noise();
    repeat ($urandom_range(1, 10)) begin
      push_byte(base_t'($urandom_range(255)), $urandom_range(9) == 0);
    end
  endtask

  // new pattern per block; the first few blocks take the extreme settings
  task automatic pick_pattern(input int blk);
    int                 len;
    int                 r;
    logic [2*CFG_W-1:0] codes;
    logic [CFG_W-1:0]   len_word;
    for (int j = 0; j < SYM_CNT; j++) begin
      codes[CODE_W*j +: CODE_W] = ($urandom_range(99) < 75) ? CODE_W'($urandom_range(3)) :
                                                               CODE_W'($urandom_range(4, 15));
    end
    if ($urandom_range(9) == 0) codes = {$urandom, $urandom, $urandom, $urandom};
    case (blk)
      0: len = PATTERN_MAX_DEFAULT;
      1: len = 0;
      2: begin
        // length above the window, all wildcards: a hit on every base once the window is full
        len   = 63;
        codes = '1;
      end
      3: begin
        len   = 5;
        codes = '0;
      end
      default: begin
        r = $urandom_range(99);
        if (r < 60)      len = $urandom_range(1, 8);
        else if (r < 90) len = $urandom_range(9, 32);
        else if (r < 95) len = $urandom_range(33, 63);
        else             len = 0;
      end
    endcase
    // upper bits of the length word are don't-care, so toggle them too
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = LEN_W'(len);
    write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_SYMBOLS_LOW, codes[CFG_W-1:0]);
    write_reg(REG_SYMBOLS_HIGH, codes[2*CFG_W-1:CFG_W]);
  endtask

  initial begin : stimulus
    int blk;
    int block_end;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset pattern is a single A
    push_word("At");                   // forward at 1, folded t gives reverse complement at 2
    push_byte(CH_SPACE, 1'b0);         // blanks are dropped
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_word("CN");                   // C and N miss
    push_byte(CH_ZERO, 1'b0);
    push_byte(CH_ONES, 1'b0);
    push_byte(CHAR_T, 1'b1);           // hit on the last base, then cleared
    push_byte(CH_LF, 1'b1);            // end of record on a blank still clears
    push_word("a");                    // position restarts at 1
    quiesce();

    // ACGT is its own reverse complement, forward has precedence
    write_reg(REG_PATTERN_LENGTH, CFG_W'(4));
    write_reg(REG_SYMBOLS_LOW, {48'h0, CODE_T, CODE_G, CODE_C, CODE_A});
    push_word("acgt");
    quiesce();

    // AAC only seen on the other strand as GTT
    write_reg(REG_PATTERN_LENGTH, CFG_W'(3));
    write_reg(REG_SYMBOLS_LOW, {52'h0, CODE_C, CODE_A, CODE_A});
    push_word("GTT");
    quiesce();

    // top wildcard code lets N through
    write_reg(REG_PATTERN_LENGTH, CFG_W'(2));
    write_reg(REG_SYMBOLS_LOW, {56'h0, CODE_G, 4'hf});
    push_word("NG");
    quiesce();

    // zero length never checks a window
    write_reg(REG_PATTERN_LENGTH, CFG_W'(0));
    write_reg(REG_SYMBOLS_HIGH, '1);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    push_word("AC");
    quiesce();

    // random part: blocks of records, pattern and idling change while drained
    bases_sent = 0;
    blk        = 0;
    while (bases_sent < RANDOM_BASES) begin
      pick_pattern(blk);
      case (blk % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 78;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 78;
        end
        default: begin
          gap_pct   = 13;
          stall_pct = 13;
        end
      endcase
      block_end = bases_sent + BLOCK_BASES;
      while (bases_sent < block_end) begin
        if ($urandom_range(9) == 0) send_noise();
        else                        send_record();
      end
      quiesce();
      blk++;
    end

    // anything still predicted now is a lost hit
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatch_count == 0 && !stuck) begin
      $display("dna_kmer_wildcard_match_unit verification clean");
    end else begin
      $display("dna_kmer_wildcard_match_unit verification failed");
    end
    $finish;
  end

endmodule
